[rtl/rspa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rspa_pkg: shared types and constants of the record slot page allocator
// Slot count, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package rspa_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int REC_W  = 64;

	typedef logic [2:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t K_INSERT = 3'd0;
	localparam kind_t K_GET    = 3'd1;
	localparam kind_t K_DELETE = 3'd2;
	localparam kind_t K_UPDATE = 3'd3;
	localparam kind_t K_HAS    = 3'd4;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_UNUSED = 2'd2;

endpackage
`default_nettype wire

[rtl/rspa_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rspa_ifs: request and response channels of the record slot page allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rspa_req_if;
	import rspa_pkg::*;

	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [SLOT_W-1:0]  slot;
	logic [REC_W-1:0]   record;

	modport source(output valid, kind, slot, record, input ready);
	modport sink(input valid, kind, slot, record, output ready);
endinterface

interface rspa_rsp_if;
	import rspa_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [SLOT_W-1:0]  slot_out;
	logic [REC_W-1:0]   record_out;
	logic               present;
	logic [CNT_W-1:0]   used_count;

	modport source(output valid, status, slot_out, record_out, present, used_count,
		input ready);
	modport sink(input valid, status, slot_out, record_out, present, used_count,
		output ready);
endinterface
`default_nettype wire

[rtl/record_slot_page_allocator.sv]
`default_nettype none
// A request is accepted into the request stage, where the record memory is read; the
// bitmap search and write-back follow as it moves on to the output register, once that
// register is empty or its item is being taken. The stage holds one request at a time.
// A finished response waits in the output register while the next request is accepted.
// Reset clears the used-slot bitmap, the occupancy count and the next-free pointer and sets
// capacity to 64; the record memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// record_slot_page_allocator
// Fixed-record page: used-slot bitmap, next-fit free pointer and a record
// memory with one word per slot; insert, get, delete, update, has-record.
// ----------------------------------------------------------------------------
module record_slot_page_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rspa_pkg::CNT_W-1:0] cfg_wdata,
	rspa_req_if.sink                   req,
	rspa_rsp_if.source                 rsp
);
	import rspa_pkg::*;

	// configuration and page state
	logic [CNT_W-1:0]  cap_q;
	logic [SLOTS-1:0]  used_q;
	logic [SLOT_W-1:0] nf_q;
	logic [CNT_W-1:0]  occ_q;

	// request stage
	logic              busy_s1;
	kind_t             kind_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [REC_W-1:0]  rec_s1;
	logic [REC_W-1:0]  rdata_s1;

	// record memory
	logic [REC_W-1:0]  mem [SLOTS];

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic [REC_W-1:0]  rec_out_q;
	logic              present_q;
	logic [CNT_W-1:0]  cnt_out_q;

	// next response item
	status_t           status_d;
	logic [SLOT_W-1:0] slot_out_d;
	logic [REC_W-1:0]  rec_out_d;
	logic              present_d;
	logic [CNT_W-1:0]  cnt_out_d;

	logic              req_acc;
	logic              done;
	logic [SLOTS-1:0]  free_all;
	logic [SLOTS-1:0]  free_hi;
	logic              hi_found;
	logic              lo_found;
	logic [SLOT_W-1:0] hi_idx;
	logic [SLOT_W-1:0] lo_idx;
	logic              ins_found;
	logic [SLOT_W-1:0] ins_slot;
	logic              slot_ok;
	logic [SLOTS-1:0]  used_del;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = !busy_s1;
	assign done      = busy_s1 && (!out_valid_q || rsp.ready);

	// find free slots below capacity, and those of them at or above the pointer
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_all[i] = !used_q[i] && (CNT_W'(i) < cap_q);
			free_hi[i]  = free_all[i] && (SLOT_W'(i) >= nf_q);
		end
	end

	// pick the lowest free slot at or above the pointer and the lowest free slot overall
	always_comb begin
		hi_found = 1'b0;
		lo_found = 1'b0;
		hi_idx   = '0;
		lo_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_hi[i]) begin
				hi_found = 1'b1;
				hi_idx   = SLOT_W'(i);
			end
			if (free_all[i]) begin
				lo_found = 1'b1;
				lo_idx   = SLOT_W'(i);
			end
		end
	end

	assign ins_found = hi_found || lo_found;
	assign ins_slot  = hi_found ? hi_idx : lo_idx;
	assign slot_ok   = ({1'b0, slot_s1} < cap_q) && used_q[slot_s1];

	// bitmap as it stands once the delete has cleared its slot
	always_comb begin
		used_del          = used_q;
		used_del[slot_s1] = 1'b0;
	end

	// write back the record on insert and update
	assign mem_we    = done && ((kind_s1 == K_INSERT && ins_found) ||
		(kind_s1 == K_UPDATE && slot_ok));
	assign mem_waddr = (kind_s1 == K_INSERT) ? ins_slot : slot_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= rec_s1;
		end
		if (req_acc) begin
			rdata_s1 <= mem[req.slot];
		end
	end

	// hold the request payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_s1 <= req.kind;
			slot_s1 <= req.slot;
			rec_s1  <= req.record;
		end
	end

	// advance the request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req_acc) begin
			busy_s1 <= 1'b1;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	// capacity register, clamped to 1..SLOTS on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(SLOTS);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cap_q <= CNT_W'(1);
			end else if (cfg_wdata > CNT_W'(SLOTS)) begin
				cap_q <= CNT_W'(SLOTS);
			end else begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// update bitmap, pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			nf_q   <= '0;
			occ_q  <= '0;
		end else if (done) begin
			if (kind_s1 == K_INSERT && ins_found) begin
				used_q[ins_slot] <= 1'b1;
				nf_q             <= ins_slot;
				occ_q            <= occ_q + CNT_W'(1);
			end else if (kind_s1 == K_DELETE && slot_ok) begin
				used_q <= used_del;
				occ_q  <= occ_q - CNT_W'(1);
				if (used_del[nf_q] || nf_q < slot_s1) begin
					nf_q <= slot_s1;
				end
			end
		end
	end

	// output valid: set on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// build the response item
	always_comb begin
		status_d   = ST_OK;
		slot_out_d = slot_s1;
		rec_out_d  = '0;
		present_d  = 1'b0;
		cnt_out_d  = occ_q;
		priority if (kind_s1 == K_INSERT) begin
			if (ins_found) begin
				slot_out_d = ins_slot;
				present_d  = 1'b1;
				cnt_out_d  = occ_q + CNT_W'(1);
			end else begin
				status_d   = ST_FULL;
				slot_out_d = '0;
			end
		end else if (kind_s1 == K_GET || kind_s1 == K_DELETE ||
			kind_s1 == K_UPDATE || kind_s1 == K_HAS) begin
			if (slot_ok) begin
				present_d = 1'b1;
				if (kind_s1 == K_GET) begin
					rec_out_d = rdata_s1;
				end
				if (kind_s1 == K_DELETE) begin
					cnt_out_d = occ_q - CNT_W'(1);
				end
			end else begin
				status_d = ST_UNUSED;
			end
		end else begin
			status_d = ST_UNUSED;
		end
	end

	// load the response item
	always_ff @(posedge clk) begin
		if (done) begin
			status_q   <= status_d;
			slot_out_q <= slot_out_d;
			rec_out_q  <= rec_out_d;
			present_q  <= present_d;
			cnt_out_q  <= cnt_out_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_out   = slot_out_q;
	assign rsp.record_out = rec_out_q;
	assign rsp.present    = present_q;
	assign rsp.used_count = cnt_out_q;

	// the count tracks the bitmap
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == occ_q)
		else $error("occupancy count differs from bitmap");

	// an insert marks the slot it reports
	a_insert_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind_s1 == K_INSERT && ins_found) |=> used_q[$past(ins_slot)])
		else $error("inserted slot not marked used");

	// a delete clears its slot
	a_delete_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind_s1 == K_DELETE && slot_ok) |=> !used_q[$past(slot_s1)])
		else $error("deleted slot still marked used");

	// no request is taken while one is in work
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && !done) |=> busy_s1)
		else $error("request stage lost an item");

endmodule
`default_nettype wire
